// ===== hdl/ftpid_pkg.sv =====
`timescale 1ns / 1ps
// ftpid_pkg: shared constants, types and command struct for the filtered pid block
// depends on nothing

package ftpid_pkg;

  localparam int DATA_W           = 32;
  localparam int CFG_DATA_W       = 48;
  localparam int CFG_IDX_W        = 3;
  localparam int TAP_W            = 16;
  localparam int FIR_FRAC         = 14;
  localparam int GAIN_FRAC        = 16;
  localparam int ERR_PACKED_TAPS  = 3;
  localparam int DT_PACKED_TAPS   = 6;
  localparam int MAX_FILTER_TAPS  = 8;
  localparam int TAP_IDX_W        = $clog2(MAX_FILTER_TAPS);

  localparam int ERROR_FILTER_TAPS_DEF = 3;
  localparam int DTERM_FILTER_TAPS_DEF = 6;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [CFG_DATA_W-1:0] TAPS_UNITY = CFG_DATA_W'(16384);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP          = 3'd0,
    REG_KI_HALF     = 3'd1,
    REG_KD_TWICE    = 3'd2,
    REG_UPPER       = 3'd3,
    REG_LOWER       = 3'd4,
    REG_ERR_TAPS    = 3'd5,
    REG_DT_TAPS_LO  = 3'd6,
    REG_DT_TAPS_HI  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki_half_period;
    logic signed [DATA_W-1:0] kd_twice_rate;
    logic signed [DATA_W-1:0] upper_limit;
    logic signed [DATA_W-1:0] lower_limit;
    logic [CFG_DATA_W-1:0]    error_taps;
    logic [CFG_DATA_W-1:0]    dterm_taps_low;
    logic [CFG_DATA_W-1:0]    dterm_taps_high;
  } cfg_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_ERR_TAP,
    MUL_DT_TAP,
    MUL_KP,
    MUL_KD,
    MUL_KI
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR_MAC,
    ST_ERR_SUM,
    ST_ERR_RND,
    ST_GAIN_P,
    ST_GAIN_D,
    ST_GAIN_I,
    ST_DT_IN,
    ST_DT_MAC,
    ST_DT_SUM,
    ST_DT_RND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 load;      // capture raw error, clear accumulator
    mul_sel_t             mul_sel;
    logic [TAP_IDX_W-1:0] tap_idx;
    logic                 mac;       // product joins the accumulator next cycle
    logic                 e_wr;      // round filtered error, shift error history
    logic                 diff_wr;   // form e - last_error and e + last_error
    logic                 p_wr;
    logic                 gd_wr;
    logic                 dt_start;  // gi, raw derivative, clear accumulator
    logic                 d_wr;      // round derivative, shift history, integral
    logic                 out_wr;    // clamp, output register, state update
  } cmd_t;

endpackage

// ===== hdl/ftpid_in_if.sv =====
`timescale 1ns / 1ps
// ftpid_in_if: input sample channel, valid/ready with feedback and setpoint
// depends on ftpid_pkg

interface ftpid_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ftpid_pkg::DATA_W-1:0]   feedback;
  logic signed [ftpid_pkg::DATA_W-1:0]   setpoint;

  modport source (output valid, feedback, setpoint, input ready);
  modport sink   (input valid, feedback, setpoint, output ready);
endinterface

// ===== hdl/ftpid_out_if.sv =====
`timescale 1ns / 1ps
// ftpid_out_if: result channel, valid/ready with drive and saturated flag
// depends on ftpid_pkg

interface ftpid_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ftpid_pkg::DATA_W-1:0]   drive;
  logic                                  saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

// ===== hdl/ftpid_cfg_if.sv =====
`timescale 1ns / 1ps
// ftpid_cfg_if: configuration write channel, valid/ready with index and data
// depends on ftpid_pkg

interface ftpid_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ftpid_pkg::CFG_IDX_W-1:0]       index;
  logic [ftpid_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ftpid_regs.sv =====
`timescale 1ns / 1ps
// ftpid_regs: configuration register bank with write decode
// depends on ftpid_pkg

module ftpid_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [ftpid_pkg::CFG_IDX_W-1:0]   wr_idx,
  input  logic [ftpid_pkg::CFG_DATA_W-1:0]  wr_data,
  output ftpid_pkg::cfg_t                   cfg
);

  ftpid_pkg::cfg_t regs;
  ftpid_pkg::cfg_t regs_next;

  always_comb begin
    regs_next = regs;
    if (wr_en) begin
      unique case (ftpid_pkg::reg_idx_t'(wr_idx))
        ftpid_pkg::REG_KP:         regs_next.kp              = wr_data[ftpid_pkg::DATA_W-1:0];
        ftpid_pkg::REG_KI_HALF:    regs_next.ki_half_period  = wr_data[ftpid_pkg::DATA_W-1:0];
        ftpid_pkg::REG_KD_TWICE:   regs_next.kd_twice_rate   = wr_data[ftpid_pkg::DATA_W-1:0];
        ftpid_pkg::REG_UPPER:      regs_next.upper_limit     = wr_data[ftpid_pkg::DATA_W-1:0];
        ftpid_pkg::REG_LOWER:      regs_next.lower_limit     = wr_data[ftpid_pkg::DATA_W-1:0];
        ftpid_pkg::REG_ERR_TAPS:   regs_next.error_taps      = wr_data;
        ftpid_pkg::REG_DT_TAPS_LO: regs_next.dterm_taps_low  = wr_data;
        ftpid_pkg::REG_DT_TAPS_HI: regs_next.dterm_taps_high = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp              <= '0;
      regs.ki_half_period  <= '0;
      regs.kd_twice_rate   <= '0;
      regs.upper_limit     <= ftpid_pkg::Q_MAX;
      regs.lower_limit     <= ftpid_pkg::Q_MIN;
      regs.error_taps      <= ftpid_pkg::TAPS_UNITY;
      regs.dterm_taps_low  <= ftpid_pkg::TAPS_UNITY;
      regs.dterm_taps_high <= '0;
    end else begin
      regs <= regs_next;
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/ftpid_ctrl.sv =====
`timescale 1ns / 1ps
// ftpid_ctrl: sequencer that steps the shared multiplier through one sample
// depends on ftpid_pkg

module ftpid_ctrl #(
  parameter int ERROR_FILTER_TAPS = ftpid_pkg::ERROR_FILTER_TAPS_DEF,
  parameter int DTERM_FILTER_TAPS = ftpid_pkg::DTERM_FILTER_TAPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ftpid_pkg::cmd_t    cmd
);

  localparam logic [ftpid_pkg::TAP_IDX_W-1:0] ERR_LAST =
    ftpid_pkg::TAP_IDX_W'(ERROR_FILTER_TAPS - 1);
  localparam logic [ftpid_pkg::TAP_IDX_W-1:0] DT_LAST =
    ftpid_pkg::TAP_IDX_W'(DTERM_FILTER_TAPS - 1);

  ftpid_pkg::state_t               state, state_next;
  logic [ftpid_pkg::TAP_IDX_W-1:0] cnt, cnt_next;
  logic                            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftpid_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_sel    = ftpid_pkg::MUL_KP;
    cmd.tap_idx    = cnt;
    unique case (state)
      ftpid_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ftpid_pkg::ST_ERR_MAC;
        end
      end
      ftpid_pkg::ST_ERR_MAC: begin
        cmd.mul_sel = ftpid_pkg::MUL_ERR_TAP;
        cmd.mac     = 1'b1;
        if (cnt == ERR_LAST) begin
          cnt_next   = '0;
          state_next = ftpid_pkg::ST_ERR_SUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ftpid_pkg::ST_ERR_SUM: state_next = ftpid_pkg::ST_ERR_RND;
      ftpid_pkg::ST_ERR_RND: begin
        cmd.e_wr   = 1'b1;
        state_next = ftpid_pkg::ST_GAIN_P;
      end
      ftpid_pkg::ST_GAIN_P: begin
        cmd.mul_sel = ftpid_pkg::MUL_KP;
        cmd.diff_wr = 1'b1;
        state_next  = ftpid_pkg::ST_GAIN_D;
      end
      ftpid_pkg::ST_GAIN_D: begin
        cmd.mul_sel = ftpid_pkg::MUL_KD;
        cmd.p_wr    = 1'b1;
        state_next  = ftpid_pkg::ST_GAIN_I;
      end
      ftpid_pkg::ST_GAIN_I: begin
        cmd.mul_sel = ftpid_pkg::MUL_KI;
        cmd.gd_wr   = 1'b1;
        state_next  = ftpid_pkg::ST_DT_IN;
      end
      ftpid_pkg::ST_DT_IN: begin
        cmd.dt_start = 1'b1;
        cnt_next     = '0;
        state_next   = ftpid_pkg::ST_DT_MAC;
      end
      ftpid_pkg::ST_DT_MAC: begin
        cmd.mul_sel = ftpid_pkg::MUL_DT_TAP;
        cmd.mac     = 1'b1;
        if (cnt == DT_LAST) begin
          cnt_next   = '0;
          state_next = ftpid_pkg::ST_DT_SUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ftpid_pkg::ST_DT_SUM: state_next = ftpid_pkg::ST_DT_RND;
      ftpid_pkg::ST_DT_RND: begin
        cmd.d_wr   = 1'b1;
        state_next = ftpid_pkg::ST_OUT;
      end
      ftpid_pkg::ST_OUT: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_wr     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ftpid_pkg::ST_IDLE;
        end
      end
      default: state_next = ftpid_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/ftpid_dp.sv =====
`timescale 1ns / 1ps
// ftpid_dp: datapath with shared multiplier, accumulator, filter histories and clamp
// depends on ftpid_pkg

module ftpid_dp #(
  parameter int ERROR_FILTER_TAPS = ftpid_pkg::ERROR_FILTER_TAPS_DEF,
  parameter int DTERM_FILTER_TAPS = ftpid_pkg::DTERM_FILTER_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ftpid_pkg::cmd_t                     cmd,
  input  ftpid_pkg::cfg_t                     cfg,
  input  logic signed [ftpid_pkg::DATA_W-1:0] feedback,
  input  logic signed [ftpid_pkg::DATA_W-1:0] setpoint,
  output logic signed [ftpid_pkg::DATA_W-1:0] drive,
  output logic                                saturated
);

  localparam int W  = ftpid_pkg::DATA_W;
  localparam int PW = 2 * W;
  localparam int IW = ftpid_pkg::TAP_IDX_W;
  localparam int TW = ftpid_pkg::TAP_W;

  function automatic logic signed [W-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [W-1:0] r;
    if (v[PW-1:W-1] == '0 || v[PW-1:W-1] == '1) begin
      r = v[W-1:0];
    end else if (v[PW-1]) begin
      r = ftpid_pkg::Q_MIN;
    end else begin
      r = ftpid_pkg::Q_MAX;
    end
    return r;
  endfunction

  // round half up then floor, then saturate
  function automatic logic signed [W-1:0] round_sat(input logic signed [PW-1:0] v,
                                                    input int sh);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< (sh - 1))) >>> sh;
    return sat32(t);
  endfunction

  function automatic logic signed [W-1:0] err_tap(input logic [ftpid_pkg::CFG_DATA_W-1:0] taps,
                                                  input logic [IW-1:0] idx);
    logic signed [W-1:0] t;
    t = '0;
    for (int k = 0; k < ftpid_pkg::ERR_PACKED_TAPS; k++) begin
      if (idx == IW'(k)) t = W'(signed'(taps[TW*k +: TW]));
    end
    return t;
  endfunction

  function automatic logic signed [W-1:0] dt_tap(input logic [2*ftpid_pkg::CFG_DATA_W-1:0] taps,
                                                 input logic [IW-1:0] idx);
    logic signed [W-1:0] t;
    t = '0;
    for (int k = 0; k < ftpid_pkg::DT_PACKED_TAPS; k++) begin
      if (idx == IW'(k)) t = W'(signed'(taps[TW*k +: TW]));
    end
    return t;
  endfunction

  // working registers
  logic signed [W-1:0]  err_raw, e, ediff, esum, p_term, gd, gi, d0, d_term, integ;
  logic signed [PW-1:0] prod, acc;
  logic                 acc_pend;

  // controller state carried between samples
  logic signed [W-1:0]  integral_acc, last_error, last_dterm;
  logic                 sat_mark;

  logic signed [W-1:0]  esample, dsample, mul_a, mul_b;
  logic signed [W-1:0]  sum_sat, drive_next;
  logic signed [W+1:0]  sum_wide;
  logic                 sat_next;

  // error filter history
  generate
    if (ERROR_FILTER_TAPS > 1) begin : g_err_hist
      logic signed [W-1:0] hist [ERROR_FILTER_TAPS-1];
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int k = 0; k < ERROR_FILTER_TAPS - 1; k++) hist[k] <= '0;
        end else if (cmd.e_wr) begin
          hist[0] <= err_raw;
          for (int k = 1; k < ERROR_FILTER_TAPS - 1; k++) hist[k] <= hist[k-1];
        end
      end
      always_comb begin
        esample = err_raw;
        for (int k = 0; k < ERROR_FILTER_TAPS - 1; k++) begin
          if (cmd.tap_idx == IW'(k + 1)) esample = hist[k];
        end
      end
    end else begin : g_err_nohist
      assign esample = err_raw;
    end
  endgenerate

  // derivative filter history
  generate
    if (DTERM_FILTER_TAPS > 1) begin : g_dt_hist
      logic signed [W-1:0] hist [DTERM_FILTER_TAPS-1];
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int k = 0; k < DTERM_FILTER_TAPS - 1; k++) hist[k] <= '0;
        end else if (cmd.d_wr) begin
          hist[0] <= d0;
          for (int k = 1; k < DTERM_FILTER_TAPS - 1; k++) hist[k] <= hist[k-1];
        end
      end
      always_comb begin
        dsample = d0;
        for (int k = 0; k < DTERM_FILTER_TAPS - 1; k++) begin
          if (cmd.tap_idx == IW'(k + 1)) dsample = hist[k];
        end
      end
    end else begin : g_dt_nohist
      assign dsample = d0;
    end
  endgenerate

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      ftpid_pkg::MUL_ERR_TAP: begin
        mul_a = err_tap(cfg.error_taps, cmd.tap_idx);
        mul_b = esample;
      end
      ftpid_pkg::MUL_DT_TAP: begin
        mul_a = dt_tap({cfg.dterm_taps_high, cfg.dterm_taps_low}, cmd.tap_idx);
        mul_b = dsample;
      end
      ftpid_pkg::MUL_KD: begin
        mul_a = cfg.kd_twice_rate;
        mul_b = ediff;
      end
      ftpid_pkg::MUL_KI: begin
        mul_a = cfg.ki_half_period;
        mul_b = esum;
      end
      default: begin
        mul_a = cfg.kp;
        mul_b = e;
      end
    endcase
  end

  // output sum and clamp, upper test first
  always_comb begin
    sum_wide = (W+2)'(p_term) + (W+2)'(integ) + (W+2)'(d_term);
    sum_sat  = sat32(PW'(sum_wide));
    if (sum_sat > cfg.upper_limit) begin
      drive_next = cfg.upper_limit;
      sat_next   = 1'b1;
    end else if (sum_sat < cfg.lower_limit) begin
      drive_next = cfg.lower_limit;
      sat_next   = 1'b1;
    end else begin
      drive_next = sum_sat;
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.mac;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load || cmd.dt_start) begin
      acc <= '0;
    end else if (acc_pend) begin
      acc <= acc + prod;
    end
    if (cmd.load) err_raw <= sat32(PW'(setpoint) - PW'(feedback));
    if (cmd.e_wr) e <= round_sat(acc, ftpid_pkg::FIR_FRAC);
    if (cmd.diff_wr) begin
      ediff <= sat32(PW'(e) - PW'(last_error));
      esum  <= sat32(PW'(e) + PW'(last_error));
    end
    if (cmd.p_wr)  p_term <= round_sat(prod, ftpid_pkg::GAIN_FRAC);
    if (cmd.gd_wr) gd     <= round_sat(prod, ftpid_pkg::GAIN_FRAC);
    if (cmd.dt_start) begin
      gi <= round_sat(prod, ftpid_pkg::GAIN_FRAC);
      d0 <= sat32(PW'(gd) - PW'(last_dterm));
    end
    if (cmd.d_wr) begin
      d_term <= round_sat(acc, ftpid_pkg::FIR_FRAC);
      integ  <= sat_mark ? '0 : sat32(PW'(integral_acc) + PW'(gi));
    end
    if (cmd.out_wr) begin
      drive     <= drive_next;
      saturated <= sat_next;
    end
  end

  // state carried to the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      last_error   <= '0;
      last_dterm   <= '0;
      sat_mark     <= 1'b0;
    end else if (cmd.out_wr) begin
      integral_acc <= integ;
      last_error   <= e;
      last_dterm   <= d_term;
      sat_mark     <= sat_next;
    end
  end

endmodule

// ===== hdl/filtered_tustin_pid_controller_top.sv =====
`timescale 1ns / 1ps
// filtered_tustin_pid_controller_top: filtered pid controller with tustin derivative
// depends on ftpid_pkg, the three channel interfaces, ftpid_regs, ftpid_ctrl, ftpid_dp
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   feedback, setpoint (signed q16.16)
//   results   out  valid/ready   drive (signed q16.16), saturated
//   cfg       in   valid/ready   index (3 bit), data (48 bit)
//
// each item passes through the error filter taps, the three gains and the derivative
// filter taps in turn, all on the single shared 32x32 multiplier
// that issues one product per cycle for the filter taps and the three gains
// samples are taken only while the sequencer is idle; a result sits in the output
// register until taken, and the next sample is accepted meanwhile
// a stalled result holds the sequencer in its final step; synchronous reset clears
// controller state, filter histories and cfg registers to their reset values
// cfg writes are always taken and belong in idle periods

module filtered_tustin_pid_controller_top #(
  parameter int ERROR_FILTER_TAPS = ftpid_pkg::ERROR_FILTER_TAPS_DEF,
  parameter int DTERM_FILTER_TAPS = ftpid_pkg::DTERM_FILTER_TAPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ftpid_in_if.sink     samples,
  ftpid_out_if.source  results,
  ftpid_cfg_if.sink    cfg
);

  ftpid_pkg::cfg_t cfg_regs;   // current register values
  ftpid_pkg::cmd_t cmd;        // sequencer to datapath

  // the register bank never stalls a write
  assign cfg.ready = 1'b1;

  ftpid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg.valid),
    .wr_idx  (cfg.index),
    .wr_data (cfg.data),
    .cfg     (cfg_regs)
  );

  // sequencer: sample handshake, step order, output valid
  ftpid_ctrl #(
    .ERROR_FILTER_TAPS (ERROR_FILTER_TAPS),
    .DTERM_FILTER_TAPS (DTERM_FILTER_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  // datapath: error filter, gains, derivative filter, integral, clamp
  ftpid_dp #(
    .ERROR_FILTER_TAPS (ERROR_FILTER_TAPS),
    .DTERM_FILTER_TAPS (DTERM_FILTER_TAPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg_regs),
    .feedback  (samples.feedback),
    .setpoint  (samples.setpoint),
    .drive     (results.drive),
    .saturated (results.saturated)
  );

endmodule

// ===== tb/filtered_tustin_pid_controller_top_tb.sv =====
`timescale 1ns / 1ps
// filtered_tustin_pid_controller_top_tb: self-checking bench for the filtered tustin pid block
// depends on ftpid_pkg, ftpid_in_if, ftpid_out_if, ftpid_cfg_if, filtered_tustin_pid_controller_top

module filtered_tustin_pid_controller_top_tb;
  import ftpid_pkg::*;

  // generous cycle ceiling, several times the slowest legal run
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_COUNT   = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int TAIL_CYCLES   = 40;
  localparam int ERR_HIST      = ERROR_FILTER_TAPS_DEF - 1;
  localparam int DT_HIST       = DTERM_FILTER_TAPS_DEF - 1;
  localparam longint S32_MAX   = 64'sh7FFF_FFFF;
  localparam longint S32_MIN   = -64'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  // flavors of register settings used by the random phases
  typedef enum int {CFG_TAME, CFG_WILD, CFG_EXTREME} cfg_style_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
  } drive_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ftpid_in_if  samples ();
  ftpid_out_if results ();
  ftpid_cfg_if cfg ();

  filtered_tustin_pid_controller_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted drive values, oldest first
  drive_item_t expected_drive_q[$];
  int          failures    = 0;
  int          cycle_count = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;

  // controller image: registers plus running state
  cfg_t   shadow_cfg;
  longint integ_acc;
  longint prev_err;
  longint prev_dterm;
  bit     last_sat;
  longint err_hist [ERR_HIST];
  longint dt_hist  [DT_HIST];

  // ---------------------------------------------------------------------------
  // fixed point helpers
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // add half an lsb, then floor (arithmetic shift of a signed longint)
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // q16.16 times q16.16, back to q16.16
  function automatic longint gain_mul(longint g, longint x);
    return clamp32(round_shift(g * x, GAIN_FRAC));
  endfunction

  function automatic longint tap_coef(logic [CFG_DATA_W-1:0] packed_taps, int k);
    logic signed [TAP_W-1:0] t;
    t = packed_taps[TAP_W*k +: TAP_W];
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // controller image
  // ---------------------------------------------------------------------------

  function automatic void reset_pid_model();
    shadow_cfg.kp              = '0;
    shadow_cfg.ki_half_period  = '0;
    shadow_cfg.kd_twice_rate   = '0;
    shadow_cfg.upper_limit     = Q_MAX;
    shadow_cfg.lower_limit     = Q_MIN;
    shadow_cfg.error_taps      = TAPS_UNITY;
    shadow_cfg.dterm_taps_low  = TAPS_UNITY;
    shadow_cfg.dterm_taps_high = '0;
    integ_acc  = 0;
    prev_err   = 0;
    prev_dterm = 0;
    last_sat   = 1'b0;
    foreach (err_hist[i]) err_hist[i] = 0;
    foreach (dt_hist[i]) dt_hist[i] = 0;
  endfunction

  // 32 bit registers keep the low bits of the written word
  function automatic void apply_cfg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_KP:         shadow_cfg.kp              = value[DATA_W-1:0];
      REG_KI_HALF:    shadow_cfg.ki_half_period  = value[DATA_W-1:0];
      REG_KD_TWICE:   shadow_cfg.kd_twice_rate   = value[DATA_W-1:0];
      REG_UPPER:      shadow_cfg.upper_limit     = value[DATA_W-1:0];
      REG_LOWER:      shadow_cfg.lower_limit     = value[DATA_W-1:0];
      REG_ERR_TAPS:   shadow_cfg.error_taps      = value;
      REG_DT_TAPS_LO: shadow_cfg.dterm_taps_low  = value;
      REG_DT_TAPS_HI: shadow_cfg.dterm_taps_high = value;
      default: ;
    endcase
  endfunction

  // one control step: filtered error, p, tustin d through its fir, trapezoidal i, clamp
  function automatic drive_item_t predict_drive(logic signed [DATA_W-1:0] fb,
                                                logic signed [DATA_W-1:0] sp);
    longint raw_err, err_acc, e, p, d_raw, d_acc, d, integ, sum, hi, lo, c;
    drive_item_t r;
    raw_err = clamp32(longint'(sp) - longint'(fb));

    // error fir, newest sample on tap zero
    err_acc = tap_coef(shadow_cfg.error_taps, 0) * raw_err;
    for (int i = 1; i < ERROR_FILTER_TAPS_DEF; i++) begin
      c = (i < ERR_PACKED_TAPS) ? tap_coef(shadow_cfg.error_taps, i) : 0;
      err_acc += c * err_hist[i-1];
    end
    for (int i = ERR_HIST - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
    if (ERR_HIST > 0) err_hist[0] = raw_err;
    e = clamp32(round_shift(err_acc, FIR_FRAC));

    p = gain_mul(shadow_cfg.kp, e);

    // tustin derivative, then its own fir over the unfiltered values
    d_raw = clamp32(gain_mul(shadow_cfg.kd_twice_rate, clamp32(e - prev_err)) - prev_dterm);
    d_acc = 0;
    for (int i = 0; i < DTERM_FILTER_TAPS_DEF; i++) begin
      if (i < 3) c = tap_coef(shadow_cfg.dterm_taps_low, i);
      else if (i < DT_PACKED_TAPS) c = tap_coef(shadow_cfg.dterm_taps_high, i - 3);
      else c = 0;
      d_acc += c * ((i == 0) ? d_raw : dt_hist[i-1]);
    end
    for (int i = DT_HIST - 1; i > 0; i--) dt_hist[i] = dt_hist[i-1];
    if (DT_HIST > 0) dt_hist[0] = d_raw;
    d = clamp32(round_shift(d_acc, FIR_FRAC));

    // integral is dumped, not held, after a saturated step
    if (last_sat) integ = 0;
    else integ = clamp32(integ_acc + gain_mul(shadow_cfg.ki_half_period, clamp32(e + prev_err)));

    sum = clamp32(p + integ + d);
    integ_acc  = integ;
    prev_dterm = d;
    prev_err   = e;

    // upper test wins when the limits cross
    hi = shadow_cfg.upper_limit;
    lo = shadow_cfg.lower_limit;
    if (sum > hi) begin
      sum = hi;
      r.saturated = 1'b1;
    end else if (sum < lo) begin
      sum = lo;
      r.saturated = 1'b1;
    end else begin
      r.saturated = 1'b0;
    end
    last_sat = r.saturated;
    r.drive  = sum[DATA_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers, all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int sender_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sink_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(15, 45);
  endfunction

  // valid may stay high into the next item when no gap is drawn
  task automatic send_sample(logic signed [DATA_W-1:0] fb, logic signed [DATA_W-1:0] sp);
    int gap;
    samples.valid    <= 1'b1;
    samples.feedback <= fb;
    samples.setpoint <= sp;
    do @(posedge clk); while (!samples.ready);
    expected_drive_q.push_back(predict_drive(fb, sp));
    @(negedge clk);
    gap = sender_gap();
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender goes quiet until every predicted item has come back
  task automatic drain_results();
    samples.valid <= 1'b0;
    do @(negedge clk); while (expected_drive_q.size() != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    apply_cfg(idx, value);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_taps(logic [TAP_W-1:0] t0,
                                                      logic [TAP_W-1:0] t1,
                                                      logic [TAP_W-1:0] t2);
    return {t2, t1, t0};
  endfunction

  // 32 bit register word with junk above bit 31
  function automatic logic [CFG_DATA_W-1:0] word_of(logic signed [DATA_W-1:0] w);
    logic [15:0] junk;
    junk = 16'($urandom);
    return {junk, w};
  endfunction

  function automatic logic [TAP_W-1:0] extreme_tap();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'h4000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] extreme_word();
    case ($urandom_range(0, 3))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return Q_ONE;
    endcase
  endfunction

  function automatic logic [TAP_W-1:0] tame_tap();
    return 16'(int'($urandom_range(0, 20480)) - 4096);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(reg_idx_t idx, cfg_style_t style);
    logic [CFG_DATA_W-1:0]    v;
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] span;
    v = CFG_DATA_W'({$urandom, $urandom});
    if (style == CFG_WILD) return v;
    if (style == CFG_EXTREME) begin
      if (idx == REG_ERR_TAPS || idx == REG_DT_TAPS_LO || idx == REG_DT_TAPS_HI)
        return pack_taps(extreme_tap(), extreme_tap(), extreme_tap());
      return word_of(extreme_word());
    end
    // tame: gains of a few units, wide but mostly ordered limits
    span = $urandom_range(32'h0001_0000, 32'h1000_0000);
    case (idx)
      REG_KP:       w = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      REG_KI_HALF:  w = int'($urandom_range(0, 32'h8000)) - 32'sh4000;
      REG_KD_TWICE: w = int'($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
      REG_UPPER:    w = ($urandom_range(0, 9) == 0) ? -span : span;
      REG_LOWER:    w = ($urandom_range(0, 9) == 0) ? span : -span;
      default:      return pack_taps(tame_tap(), tame_tap(), tame_tap());
    endcase
    return word_of(w);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back pressure and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    results.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        results.ready <= 1'b0;
        stall--;
      end else begin
        results.ready <= 1'b1;
        if (stalls_on) stall = sink_stall();
      end
    end
  end

  always @(posedge clk) begin : result_check
    drive_item_t want;
    if (!rst && results.valid && results.ready) begin
      if (expected_drive_q.size() == 0) begin
        $display("%0t: unexpected result, drive %h saturated %b",
                 $time, results.drive, results.saturated);
        failures++;
      end else begin
        want = expected_drive_q.pop_front();
        if (results.drive !== want.drive) begin
          $display("%0t: drive mismatch, expected %h actual %h",
                   $time, want.drive, results.drive);
          failures++;
        end
        if (results.saturated !== want.saturated) begin
          $display("%0t: saturated mismatch, expected %b actual %b",
                   $time, want.saturated, results.saturated);
          failures++;
        end
      end
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[filtered_tustin_pid_controller_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: unity error filter, zero gains, full range clamp
  task automatic test_reset_defaults();
    send_sample('0, '0);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MAX, Q_MIN);
  endtask

  // moderate gains, then gains and taps at their extremes
  task automatic test_gain_extremes();
    drain_results();
    write_reg(REG_KP,         {16'hA5A5, Q_ONE});
    write_reg(REG_KI_HALF,    {16'h5A5A, 32'sh0000_8000});
    write_reg(REG_KD_TWICE,   {16'hFFFF, 32'sh0000_4000});
    write_reg(REG_UPPER,      {16'h0000, Q_MAX});
    write_reg(REG_LOWER,      {16'h0000, Q_MIN});
    write_reg(REG_ERR_TAPS,   pack_taps(16'h2000, 16'h1000, 16'h1000));
    write_reg(REG_DT_TAPS_LO, pack_taps(16'h2000, 16'h1000, 16'hF000));
    write_reg(REG_DT_TAPS_HI, pack_taps(16'h0800, 16'h0400, 16'h0400));
    send_sample('0, 32'sh0001_8000);
    send_sample(32'sh0000_4000, 32'sh0001_8000);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MAX, Q_MAX);
    send_sample('0, '0);

    drain_results();
    write_reg(REG_KP,         {16'hFFFF, Q_MAX});
    write_reg(REG_KI_HALF,    {16'h0000, Q_MIN});
    write_reg(REG_KD_TWICE,   {16'h1234, Q_MAX});
    write_reg(REG_ERR_TAPS,   pack_taps(16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(REG_DT_TAPS_LO, pack_taps(16'h8000, 16'h8000, 16'h8000));
    write_reg(REG_DT_TAPS_HI, pack_taps(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MAX, Q_MIN);
    send_sample(32'sh0000_0001, '0);
    send_sample('0, 32'sh7FFF_0000);
    send_sample(32'shFFFF_FFFF, 32'shFFFF_FFFF);
  endtask

  // lower limit above upper limit, then an ordered narrow window
  task automatic test_crossed_limits();
    drain_results();
    write_reg(REG_KP,         word_of(Q_ONE));
    write_reg(REG_KI_HALF,    word_of('0));
    write_reg(REG_KD_TWICE,   word_of('0));
    write_reg(REG_ERR_TAPS,   TAPS_UNITY);
    write_reg(REG_DT_TAPS_LO, TAPS_UNITY);
    write_reg(REG_DT_TAPS_HI, '0);
    write_reg(REG_UPPER,      word_of(-Q_ONE));
    write_reg(REG_LOWER,      word_of(Q_ONE));
    send_sample('0, 32'sh0005_0000);
    send_sample('0, -32'sh0005_0000);
    send_sample('0, '0);

    drain_results();
    write_reg(REG_UPPER, word_of(32'sh0002_0000));
    write_reg(REG_LOWER, word_of(-32'sh0002_0000));
    send_sample('0, 32'sh0003_0000);
    send_sample('0, -32'sh0003_0000);
    send_sample('0, 32'sh0001_0000);
  endtask

  // register settings change per phase; items mostly track a held setpoint
  task automatic test_random_phases();
    cfg_style_t               style;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] fb;
    logic signed [DATA_W-1:0] sp;
    int                       r;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      // every fourth phase runs with no idling on either side
      gaps_on   = (phase % 4) != 0;
      stalls_on = (phase % 4) != 0;
      r = $urandom_range(0, 9);
      style = (r < 6) ? CFG_TAME : ((r < 8) ? CFG_WILD : CFG_EXTREME);
      if (phase == 1) style = CFG_EXTREME;
      if (phase == 2) style = CFG_WILD;
      for (int i = 0; i <= int'(REG_DT_TAPS_HI); i++)
        write_reg(reg_idx_t'(i), pick_reg_value(reg_idx_t'(i), style));

      target = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) target = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
        if (r >= 85) begin
          // noise: full range on both fields
          fb = $urandom;
          sp = $urandom;
        end else begin
          sp = target;
          fb = target + (int'($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
        end
        send_sample(fb, sp);
        // occasional full pause of the sender
        if ($urandom_range(0, 99) < 3) drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    samples.valid    = 1'b0;
    samples.feedback = '0;
    samples.setpoint = '0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    reset_pid_model();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_gain_extremes();
    test_crossed_limits();
    test_random_phases();

    drain_results();
    // let any stray item show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("[filtered_tustin_pid_controller_top] OK");
    end else begin
      $display("[filtered_tustin_pid_controller_top] ERROR");
    end
    $finish;
  end

endmodule
